/* rtl/swo_pkg.sv */
// Shared types and constants for the sensor stability / offset detector.
// No dependencies; every other file refers to it by scoped names.
package swo_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned DEC_W      = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 1'd1;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd10;
  localparam logic [DEC_W-1:0] DEC_RESET = 8'd10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W-1:0]        spread_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_SETTLE,
    S_MULT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic first;
    logic feed;
  } scan_ctrl_t;

endpackage

/* rtl/swo_if.sv */
// Valid/ready channel interfaces for sample input and result output.
// Depends on swo_pkg for payload types.
interface swo_in_if;
  logic             valid;
  logic             ready;
  swo_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swo_out_if;
  logic             valid;
  logic             ready;
  logic             taken;
  logic             stable;
  swo_pkg::sample_t offset;
  swo_pkg::spread_t spread;

  modport source (output valid, output taken, output stable, output offset, output spread,
                  input ready);
  modport sink   (input valid, input taken, input stable, input offset, input spread,
                  output ready);
endinterface

/* rtl/sensor_stability_offset_detector.sv */
// Sensor stability / offset detector. Takes one signed sample per transfer and
// returns one result per sample. A sample that is not stored goes from IDLE
// straight to EMIT; a stored sample passes UPDATE, SETTLE and MULT before EMIT,
// with SCAN after UPDATE when it overwrites the entry that holds the window
// max or min, since the window memory is then rescanned one entry per cycle
// through its single read port. Output stalls hold an item in EMIT.
// in_ch.ready is high only between items. Mean is sum / WINDOW_DEPTH toward zero.
module sensor_stability_offset_detector #(
  parameter int unsigned WINDOW_DEPTH = 80
) (
  input  logic                                clk,
  input  logic                                rst_n,
  swo_in_if.sink                              in_ch,
  swo_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [swo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swo_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned DEPTH  = WINDOW_DEPTH;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 2);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = swo_pkg::SAMPLE_W + $clog2(DEPTH);
  localparam int unsigned DW     = swo_pkg::SAMPLE_W + 1;

  localparam logic [FILL_W-1:0] FULL_C   = FILL_W'(DEPTH);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  SCAN_END = CNT_W'(DEPTH);

  swo_pkg::state_t state_r, state_nxt;

  logic [swo_pkg::TOL_W-1:0] tol_r;
  logic [swo_pkg::DEC_W-1:0] dec_r;
  logic [swo_pkg::DEC_W-1:0] skip_r, skip_nxt;
  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt, cur_w_r, cur_w_nxt;
  logic [IDX_W-1:0]  max_idx_r, max_idx_nxt, min_idx_r, min_idx_nxt;
  swo_pkg::sample_t  max_val_r, max_val_nxt, min_val_r, min_val_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  swo_pkg::sample_t  sample_r, sample_nxt;
  logic taken_r, taken_nxt, was_full_r, was_full_nxt;
  logic rs_max_r, rs_max_nxt, rs_min_r, rs_min_nxt;
  logic stable_r, stable_nxt;

  logic             out_valid_r;
  logic             out_taken_r, out_stable_r;
  swo_pkg::sample_t out_offset_r;
  swo_pkg::spread_t out_spread_r;

  logic                in_ready, in_xfer, mem_we, out_load, take, full;
  swo_pkg::scan_ctrl_t scan_ctrl;
  logic [IDX_W-1:0]    rd_addr, scan_idx;
  swo_pkg::sample_t    rdata, offset;
  logic [IDX_W-1:0]    sc_max_idx, sc_min_idx;
  swo_pkg::sample_t    sc_max_val, sc_min_val, mx, mn;
  logic [DW-1:0]       diff_fin, diff_cur;
  logic [swo_pkg::DEC_W:0] period;

  assign in_xfer  = in_ch.valid && in_ready;
  assign period   = (dec_r == '0) ? (swo_pkg::DEC_W+1)'(1) : {1'b0, dec_r};
  assign take     = ({1'b0, skip_r} + (swo_pkg::DEC_W+1)'(1)) >= period;
  assign full     = fill_r >= FULL_C;
  assign scan_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign rd_addr  = ((state_r == swo_pkg::S_SCAN) && (cnt_r < SCAN_END)) ?
                    cnt_r[IDX_W-1:0] : wr_idx_r;

  swo_window_mem #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_w_r),
    .wdata (sample_r),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  swo_scan #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_scan (
    .clk       (clk),
    .ctrl      (scan_ctrl),
    .idx_i     (scan_idx),
    .nxt_i     (cur_w_r),
    .val_i     (rdata),
    .max_idx_o (sc_max_idx),
    .max_val_o (sc_max_val),
    .min_idx_o (sc_min_idx),
    .min_val_o (sc_min_val)
  );

  swo_mean #(.DEPTH(DEPTH), .SUM_W(SUM_W)) u_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .sum_i    (sum_r),
    .offset_o (offset)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swo_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = take ? swo_pkg::S_UPDATE : swo_pkg::S_EMIT;
        end
      end
      swo_pkg::S_UPDATE: begin
        state_nxt = (rs_max_nxt || rs_min_nxt) ? swo_pkg::S_SCAN : swo_pkg::S_SETTLE;
      end
      swo_pkg::S_SCAN: begin
        if (cnt_r == SCAN_END) begin
          state_nxt = swo_pkg::S_SETTLE;
        end
      end
      swo_pkg::S_SETTLE: state_nxt = swo_pkg::S_MULT;
      swo_pkg::S_MULT:   state_nxt = swo_pkg::S_EMIT;
      swo_pkg::S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = swo_pkg::S_IDLE;
        end
      end
      default: state_nxt = swo_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready        = 1'b0;
    mem_we          = 1'b0;
    out_load        = 1'b0;
    scan_ctrl.first = 1'b0;
    scan_ctrl.feed  = 1'b0;
    case (state_r)
      swo_pkg::S_IDLE:   in_ready = 1'b1;
      swo_pkg::S_UPDATE: mem_we   = 1'b1;
      swo_pkg::S_SCAN: begin
        scan_ctrl.first = (cnt_r == CNT_W'(1));
        scan_ctrl.feed  = (cnt_r != '0);
      end
      swo_pkg::S_EMIT:   out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign mx       = rs_max_r ? sc_max_val : max_val_r;
  assign mn       = rs_min_r ? sc_min_val : min_val_r;
  assign diff_fin = DW'(mx) - DW'(mn);
  assign diff_cur = DW'(max_val_r) - DW'(min_val_r);

  // datapath
  always_comb begin
    skip_nxt     = skip_r;
    wr_idx_nxt   = wr_idx_r;
    cur_w_nxt    = cur_w_r;
    max_idx_nxt  = max_idx_r;
    min_idx_nxt  = min_idx_r;
    max_val_nxt  = max_val_r;
    min_val_nxt  = min_val_r;
    fill_nxt     = fill_r;
    sum_nxt      = sum_r;
    cnt_nxt      = '0;
    sample_nxt   = sample_r;
    taken_nxt    = taken_r;
    was_full_nxt = was_full_r;
    rs_max_nxt   = 1'b0;
    rs_min_nxt   = 1'b0;
    stable_nxt   = stable_r;
    case (state_r)
      swo_pkg::S_IDLE: begin
        if (in_xfer) begin
          sample_nxt = in_ch.sample;
          taken_nxt  = take;
          skip_nxt   = take ? '0 : skip_r + swo_pkg::DEC_W'(1);
          cur_w_nxt  = wr_idx_r;
        end
      end
      swo_pkg::S_UPDATE: begin
        was_full_nxt = full;
        stable_nxt   = 1'b0;
        sum_nxt      = sum_r - (full ? SUM_W'(rdata) : '0) + SUM_W'(sample_r);
        if (!full) begin
          if (cur_w_r == max_idx_r || max_val_r < sample_r) begin
            max_idx_nxt = cur_w_r;
            max_val_nxt = sample_r;
          end
          if (cur_w_r == min_idx_r || min_val_r > sample_r) begin
            min_idx_nxt = cur_w_r;
            min_val_nxt = sample_r;
          end
        end else begin
          if (cur_w_r == max_idx_r) begin
            rs_max_nxt = 1'b1;
          end else if (max_val_r <= sample_r) begin
            max_idx_nxt = cur_w_r;
            max_val_nxt = sample_r;
          end
          if (cur_w_r == min_idx_r) begin
            rs_min_nxt = 1'b1;
          end else if (min_val_r >= sample_r) begin
            min_idx_nxt = cur_w_r;
            min_val_nxt = sample_r;
          end
        end
        if (fill_r < FILL_MAX) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        wr_idx_nxt = (cur_w_r == LAST_IDX) ? '0 : cur_w_r + IDX_W'(1);
      end
      swo_pkg::S_SCAN: begin
        rs_max_nxt = rs_max_r;
        rs_min_nxt = rs_min_r;
        cnt_nxt    = cnt_r + CNT_W'(1);
      end
      swo_pkg::S_SETTLE: begin
        if (rs_max_r) begin
          max_idx_nxt = sc_max_idx;
          max_val_nxt = sc_max_val;
        end
        if (rs_min_r) begin
          min_idx_nxt = sc_min_idx;
          min_val_nxt = sc_min_val;
        end
        stable_nxt = was_full_r && !diff_fin[DW-1] &&
                     (diff_fin[swo_pkg::SAMPLE_W-1:0] < tol_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= swo_pkg::S_IDLE;
      tol_r     <= swo_pkg::TOL_RESET;
      dec_r     <= swo_pkg::DEC_RESET;
      skip_r    <= '0;
      wr_idx_r  <= '0;
      fill_r    <= '0;
      max_idx_r <= '0;
      min_idx_r <= '0;
      sum_r     <= '0;
      stable_r  <= 1'b0;
      rs_max_r  <= 1'b0;
      rs_min_r  <= 1'b0;
      cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      skip_r    <= skip_nxt;
      wr_idx_r  <= wr_idx_nxt;
      fill_r    <= fill_nxt;
      max_idx_r <= max_idx_nxt;
      min_idx_r <= min_idx_nxt;
      sum_r     <= sum_nxt;
      stable_r  <= stable_nxt;
      rs_max_r  <= rs_max_nxt;
      rs_min_r  <= rs_min_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          swo_pkg::REG_TOLERANCE:  tol_r <= cfg_data[swo_pkg::TOL_W-1:0];
          swo_pkg::REG_DECIMATION: dec_r <= cfg_data[swo_pkg::DEC_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_w_r     <= cur_w_nxt;
    max_val_r   <= max_val_nxt;
    min_val_r   <= min_val_nxt;
    sample_r    <= sample_nxt;
    taken_r     <= taken_nxt;
    was_full_r  <= was_full_nxt;
    if (out_load) begin
      out_taken_r  <= taken_r;
      out_stable_r <= stable_r;
      out_offset_r <= offset;
      out_spread_r <= (fill_r != '0) ? diff_cur[swo_pkg::SAMPLE_W-1:0] : '0;
    end
  end

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.taken  = out_taken_r;
  assign out_ch.stable = out_stable_r;
  assign out_ch.offset = out_offset_r;
  assign out_ch.spread = out_spread_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX) else $error("fill count past saturation");

  a_wr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= LAST_IDX) else $error("write index outside window");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready) else $error("ready while an item is in work");

  a_stable_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r |-> fill_r == FILL_MAX) else $error("stable before window filled");

  a_empty_spread: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fill_r == '0) |-> out_spread_r == '0)
    else $error("nonzero spread with empty window");

endmodule

/* rtl/swo_window_mem.sv */
// Circular sample window: one write port, one registered read port.
// Depends on swo_pkg for the sample type.
module swo_window_mem #(
  parameter int unsigned DEPTH = 80,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  swo_pkg::sample_t wdata,
  input  logic [IDX_W-1:0] raddr,
  output swo_pkg::sample_t rdata
);

  swo_pkg::sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/swo_scan.sv */
// Extremum scan unit: takes one window entry per cycle and tracks max and min
// positions; ties go to the equal entry overwritten later. Depends on swo_pkg.
module swo_scan #(
  parameter int unsigned DEPTH = 80,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  swo_pkg::scan_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic [IDX_W-1:0]    nxt_i,
  input  swo_pkg::sample_t    val_i,
  output logic [IDX_W-1:0]    max_idx_o,
  output swo_pkg::sample_t    max_val_o,
  output logic [IDX_W-1:0]    min_idx_o,
  output swo_pkg::sample_t    min_val_o
);

  localparam logic [IDX_W:0] HALF = (IDX_W+1)'(DEPTH / 2);

  logic [IDX_W-1:0] max_idx_r, max_idx_nxt, min_idx_r, min_idx_nxt;
  swo_pkg::sample_t max_val_r, max_val_nxt, min_val_r, min_val_nxt;
  logic [IDX_W:0]   i_w, n_w;
  logic             sooner;

  assign i_w    = {1'b0, idx_i};
  assign n_w    = {1'b0, nxt_i};
  assign sooner = ((i_w > n_w) && (i_w <= n_w + HALF)) || (i_w + HALF < n_w);

  always_comb begin
    max_idx_nxt = max_idx_r;
    max_val_nxt = max_val_r;
    min_idx_nxt = min_idx_r;
    min_val_nxt = min_val_r;
    if (ctrl.first) begin
      max_idx_nxt = idx_i;
      max_val_nxt = val_i;
      min_idx_nxt = idx_i;
      min_val_nxt = val_i;
    end else if (ctrl.feed) begin
      if ((val_i > max_val_r) || ((val_i == max_val_r) && !sooner)) begin
        max_idx_nxt = idx_i;
        max_val_nxt = val_i;
      end
      if ((val_i < min_val_r) || ((val_i == min_val_r) && !sooner)) begin
        min_idx_nxt = idx_i;
        min_val_nxt = val_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    max_idx_r <= max_idx_nxt;
    max_val_r <= max_val_nxt;
    min_idx_r <= min_idx_nxt;
    min_val_r <= min_val_nxt;
  end

  assign max_idx_o = max_idx_r;
  assign max_val_o = max_val_r;
  assign min_idx_o = min_idx_r;
  assign min_val_o = min_val_r;

endmodule

/* rtl/swo_mean.sv */
// Window mean: sum / DEPTH truncated toward zero, by reciprocal multiply on
// the magnitude. Two register stages, mag_r then prod_r, lie between sum and result.
module swo_mean #(
  parameter int unsigned DEPTH = 80,
  parameter int unsigned SUM_W = swo_pkg::SAMPLE_W + $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [SUM_W-1:0] sum_i,
  output swo_pkg::sample_t        offset_o
);

  localparam int unsigned SHIFT  = SUM_W + $clog2(DEPTH);
  localparam int unsigned MUL_W  = SUM_W + 2;
  localparam int unsigned PROD_W = SUM_W + MUL_W;
  localparam int unsigned Q_W    = swo_pkg::SAMPLE_W + 1;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DEPTH - 1) / DEPTH;
  localparam logic [MUL_W-1:0] RECIP_C = RECIP[MUL_W-1:0];

  logic [SUM_W-1:0]  mag_r, mag_nxt;
  logic              neg_r, neg2_r;
  logic [PROD_W-1:0] prod_r;
  logic [Q_W-1:0]    quot, res;

  assign mag_nxt = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r  <= '0;
      neg_r  <= 1'b0;
      prod_r <= '0;
      neg2_r <= 1'b0;
    end else begin
      mag_r  <= mag_nxt;
      neg_r  <= sum_i[SUM_W-1];
      prod_r <= PROD_W'(mag_r) * PROD_W'(RECIP_C);
      neg2_r <= neg_r;
    end
  end

  assign quot     = prod_r[SHIFT+Q_W-1:SHIFT];
  assign res      = neg2_r ? Q_W'(-quot) : quot;
  assign offset_o = res[swo_pkg::SAMPLE_W-1:0];

endmodule

/* bench/swo_window_checker.sv */
// Scoreboard for the sensor stability / offset detector: watches the sample,
// result and register-write ports, predicts each result and compares in order.
// Depends on swo_pkg and the channel interfaces of swo_if.sv.
module swo_window_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  swo_in_if                               in_ch,
  swo_out_if                              out_ch,
  input  logic                            cfg_we,
  input  logic [swo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swo_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending
);

  localparam int DEPTH = 80;
  localparam int HALF  = DEPTH / 2;

  typedef struct packed {
    logic             taken;
    logic             stable;
    swo_pkg::sample_t offset;
    swo_pkg::spread_t spread;
  } report_t;

  swo_pkg::sample_t win [DEPTH];
  int      wr_idx, fill, max_i, min_i, sum, skip, tol, dec;
  logic    stab;
  report_t expected_reports [$];
  int      mism;
  int      seen;

  // full pass over the window; on a tie keep the entry overwritten later
  function automatic int rescan_extreme(input bit want_max);
    int               pos;
    swo_pkg::sample_t best;
    swo_pkg::sample_t v;
    bit               cand;
    bit               sooner;
    best = win[0];
    pos  = 0;
    for (int i = 1; i < DEPTH; i++) begin
      v    = win[i];
      cand = want_max ? (v >= best) : (v <= best);
      if (cand) begin
        sooner = ((i > wr_idx) && (i <= wr_idx + HALF)) || (i + HALF < wr_idx);
        if (!(v == best && sooner)) begin
          best = v;
          pos  = i;
        end
      end
    end
    return pos;
  endfunction

  function automatic void store_sample(input swo_pkg::sample_t s);
    int w;
    w = wr_idx;
    if (fill >= DEPTH) sum -= int'(win[w]);
    win[w] = s;
    sum   += int'(s);
    stab   = 1'b0;
    if (fill < DEPTH) begin
      if (win[max_i] < s) max_i = w;
      if (win[min_i] > s) min_i = w;
    end else begin
      if (w == max_i) max_i = rescan_extreme(1'b1);
      else if (win[max_i] <= s) max_i = w;
      if (w == min_i) min_i = rescan_extreme(1'b0);
      else if (win[min_i] >= s) min_i = w;
      if (int'(win[max_i]) - int'(win[min_i]) < tol) stab = 1'b1;
    end
    if (fill < DEPTH + 1) fill++;
    w++;
    if (w >= DEPTH) w = 0;
    wr_idx = w;
  endfunction

  function automatic report_t predict_window_result(input swo_pkg::sample_t s);
    report_t r;
    int      period;
    period  = (dec == 0) ? 1 : dec;
    r.taken = 1'b0;
    if (skip + 1 >= period) begin
      skip = 0;
      store_sample(s);
      r.taken = 1'b1;
    end else begin
      skip++;
    end
    r.stable = stab;
    r.offset = swo_pkg::sample_t'(sum / DEPTH);
    r.spread = (fill != 0) ? swo_pkg::spread_t'(int'(win[max_i]) - int'(win[min_i])) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) win[i] = '0;
      wr_idx = 0;
      fill   = 0;
      max_i  = 0;
      min_i  = 0;
      sum    = 0;
      skip   = 0;
      stab   = 1'b0;
      tol    = int'(swo_pkg::TOL_RESET);
      dec    = int'(swo_pkg::DEC_RESET);
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swo_pkg::REG_TOLERANCE:  tol = int'(cfg_data[swo_pkg::TOL_W-1:0]);
          swo_pkg::REG_DECIMATION: dec = int'(cfg_data[swo_pkg::DEC_W-1:0]);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_reports.push_back(predict_window_result(in_ch.sample));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.taken, out_ch.stable, out_ch.offset, out_ch.spread};
        seen++;
        if (expected_reports.size() == 0) begin
          if (mism < 10)
            $display("checker: result transfer %0d arrived with nothing predicted", seen);
          mism++;
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            if (mism < 10) begin
              $display("checker: result %0d: exp taken=%0d stable=%0d offset=%0d spread=%0d",
                       seen, want.taken, want.stable, $signed(want.offset), want.spread);
              $display("checker: result %0d: got taken=%0d stable=%0d offset=%0d spread=%0d",
                       seen, got.taken, got.stable, $signed(got.offset), got.spread);
            end
            mism++;
          end
        end
      end
    end
    fail_count <= mism;
    pending    <= expected_reports.size();
  end

endmodule

/* bench/tb.sv */
// Top of the detector bench: clock, reset, sample and register stimulus,
// result-side stalls, watchdog and verdict. Depends on swo_pkg, swo_if.sv,
// the detector RTL and swo_window_checker.
module tb;

  localparam int QUIET_LIMIT = 4000;

  typedef enum {M_FULL, M_NEAR, M_FEW, M_EDGE} sample_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [swo_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [swo_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             fails;
  int                             pending;
  int                             quiet = 0;
  bit                             burst = 1'b0;

  swo_in_if  in_ch ();
  swo_out_if out_ch ();

  sensor_stability_offset_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  swo_window_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fails),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // result-side stalls: mostly ready, short drops, a few long ones
  initial begin
    int hold;
    int r;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(0, 20);
        end else if (r < 60) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(100, 400);
        end else if (r < 92) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(10, 150);
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  function automatic swo_pkg::sample_t make_sample(input sample_mode_t mode, input int base);
    int v;
    case (mode)
      M_NEAR: v = base + $urandom_range(0, 30) - 15;
      M_FEW:  v = base + $urandom_range(0, 4) - 2;
      M_EDGE: begin
        case ($urandom_range(0, 3))
          0:       v = 32767;
          1:       v = -32768;
          default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return swo_pkg::sample_t'(v);
  endfunction

  task automatic push_sample(input swo_pkg::sample_t s, input int gap);
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop sending and let every predicted result come back
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [swo_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[swo_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned tol, input int unsigned dec, input int n,
                           input sample_mode_t mode);
    int base;
    settle();
    write_reg(swo_pkg::REG_TOLERANCE, tol);
    write_reg(swo_pkg::REG_DECIMATION, dec);
    base = int'($urandom_range(0, 60000)) - 30000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) burst = !burst;
      if ($urandom_range(0, 99) < 2) base = int'($urandom_range(0, 60000)) - 30000;
      push_sample(make_sample(mode, base), gap_len());
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_we       = 1'b0;
    cfg_index    = swo_pkg::REG_TOLERANCE;
    cfg_data     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: nothing stored yet, window empty
    push_sample(swo_pkg::sample_t'(32767), gap_len());
    push_sample(swo_pkg::sample_t'(-32768), gap_len());
    push_sample(swo_pkg::sample_t'(0), gap_len());
    // lower decimation below the skip count
    settle();
    write_reg(swo_pkg::REG_DECIMATION, 2);
    push_sample(swo_pkg::sample_t'(12345), gap_len());
    push_sample(swo_pkg::sample_t'(-1), gap_len());
    push_sample(swo_pkg::sample_t'(-200), gap_len());
    // decimation of zero stores everything
    settle();
    write_reg(swo_pkg::REG_DECIMATION, 0);
    push_sample(swo_pkg::sample_t'(1), gap_len());
    push_sample(swo_pkg::sample_t'(-1), gap_len());
    push_sample(swo_pkg::sample_t'(32767), gap_len());
    push_sample(swo_pkg::sample_t'(-32768), gap_len());
    push_sample(swo_pkg::sample_t'(16'h5555), gap_len());
    push_sample(swo_pkg::sample_t'(16'hAAAA), gap_len());
    push_sample(swo_pkg::sample_t'(0), gap_len());

    run_phase(0, 1, 150, M_FULL);
    run_phase(65535, 1, 100, M_EDGE);
    run_phase(40, 1, 250, M_NEAR);
    run_phase(3, 1, 200, M_FEW);
    run_phase(200, 3, 200, M_NEAR);
    run_phase(10, 255, 260, M_NEAR);
    run_phase($urandom_range(0, 100), 4, 160, M_FEW);
    run_phase($urandom_range(0, 300), $urandom_range(1, 8), 180, M_FULL);

    settle();
    repeat (100) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/swo_pkg.sv
rtl/swo_if.sv
rtl/swo_window_mem.sv
rtl/swo_scan.sv
rtl/swo_mean.sv
rtl/sensor_stability_offset_detector.sv
bench/swo_window_checker.sv
bench/tb.sv
